### rtl/ila_pkg.sv
`timescale 1ns / 1ps

package ila_pkg;

    // Store and lane limits
    localparam int MAX_INTERVALS = 256;
    localparam int MAX_LANES     = 16;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 5;
    localparam int STAT_W = 2;
    localparam int ADDR_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
    localparam int LANE_W = $clog2(MAX_LANES);
    localparam int LCNT_W = $clog2(MAX_LANES + 1);
    localparam int ENTRY_W = 2 * TIME_W + LANE_W;

    localparam logic [CFG_W-1:0] MIN_LANES_RST = CFG_W'(3);

    typedef enum logic [STAT_W-1:0] {
        ST_ASSIGNED = 2'd0,
        ST_SKIPPED  = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic finish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;
        logic skip;
        logic out_free;
    } t_sts;

    // Lane count that a pass starts from, saturated to the lane limit
    function automatic logic [LCNT_W-1:0] start_lanes(input logic [CFG_W-1:0] min_lanes);
        logic [LCNT_W-1:0] res;
        if (32'(min_lanes) > MAX_LANES) begin
            res = LCNT_W'(MAX_LANES);
        end else begin
            res = LCNT_W'(min_lanes);
        end
        return res;
    endfunction

endpackage

### rtl/ila_ram.sv
`timescale 1ns / 1ps

module ila_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ila_ctrl.sv
`timescale 1ns / 1ps

module ila_ctrl import ila_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Stall whenever an interval is in hand, and through reset
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.skip) begin
                    n_state = S_FIN;
                end else if (i_sts.scan_end) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.read = 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/ila_dp.sv
`timescale 1ns / 1ps

module ila_dp import ila_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic signed [TIME_W-1:0] i_start_time,
    input  logic signed [TIME_W-1:0] i_end_time,
    input  logic                     i_in_view,
    input  logic                     i_new_pass,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic [LANE_W-1:0]        o_lane,
    output logic [LCNT_W-1:0]        o_lane_total,
    output logic [STAT_W-1:0]        o_status
);

    logic [CFG_W-1:0]         r_min;
    logic [CNT_W-1:0]         r_count;
    logic [LCNT_W-1:0]        r_lanes;
    logic [CNT_W-1:0]         r_idx;
    logic                     r_rd_vld;
    logic [MAX_LANES-1:0]     r_taken;
    logic signed [TIME_W-1:0] r_s;
    logic signed [TIME_W-1:0] r_e;
    logic                     r_view;
    logic                     r_valid;
    logic [LANE_W-1:0]        r_lane;
    logic [LCNT_W-1:0]        r_total;
    t_status                  r_status;

    logic [ENTRY_W-1:0]       rd_data;
    logic signed [TIME_W-1:0] rd_start;
    logic signed [TIME_W-1:0] rd_end;
    logic [LANE_W-1:0]        rd_lane;
    logic                     hit;
    logic                     full;
    logic                     found;
    logic [LANE_W-1:0]        free_lane;
    logic                     assign_ok;
    logic [LCNT_W-1:0]        n_lanes;

    // Interval store: start, end and lane in one entry
    ila_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (assign_ok),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({r_s, r_e, free_lane}),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_start = rd_data[ENTRY_W-1 -: TIME_W];
    assign rd_end   = rd_data[LANE_W +: TIME_W];
    assign rd_lane  = rd_data[LANE_W-1:0];

    // Inclusive overlap against the entry just read
    assign hit  = r_rd_vld && (r_s <= rd_end) && (rd_start <= r_e);
    assign full = (r_count == CNT_W'(MAX_INTERVALS));

    // Lowest lane that no overlapping interval holds
    always_comb begin
        found     = 1'b0;
        free_lane = '0;
        for (int i = MAX_LANES - 1; i >= 0; i--) begin
            if (!r_taken[i]) begin
                found     = 1'b1;
                free_lane = LANE_W'(i);
            end
        end
    end

    assign assign_ok = i_cmd.finish && r_view && !full && found;
    assign n_lanes   = (LCNT_W'(free_lane) >= r_lanes) ? LCNT_W'(free_lane) + LCNT_W'(1)
                                                       : r_lanes;

    assign o_sts.scan_end = (r_idx == r_count);
    assign o_sts.skip     = !r_view || full;
    assign o_sts.out_free = !r_valid || !i_stall;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_LANES_RST;
        end else if (i_cfg_we) begin
            r_min <= i_cfg_data;
        end
    end

    // Pass state: store fill and lane count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lanes <= start_lanes(MIN_LANES_RST);
        end else if (i_cmd.load && i_new_pass) begin
            r_count <= '0;
            r_lanes <= start_lanes(r_min);
        end else if (assign_ok) begin
            r_count <= r_count + CNT_W'(1);
            r_lanes <= n_lanes;
        end
    end

    // Capture the interval, then advance the scan and collect held lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read;
        end
        if (i_cmd.load) begin
            r_s     <= i_start_time;
            r_e     <= i_end_time;
            r_view  <= i_in_view;
            r_idx   <= '0;
            r_taken <= '0;
        end else begin
            if (i_cmd.read) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (hit) begin
                r_taken[rd_lane] <= 1'b1;
            end
        end
    end

    // Output register: load on finish, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_lane <= assign_ok ? free_lane : '0;
            r_total <= assign_ok ? n_lanes : r_lanes;
            if (!r_view) begin
                r_status <= ST_SKIPPED;
            end else if (assign_ok) begin
                r_status <= ST_ASSIGNED;
            end else begin
                r_status <= ST_REJECTED;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_lane       = r_lane;
    assign o_lane_total = r_total;
    assign o_status     = r_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_INTERVALS))
        else $error("store fill beyond capacity");

    a_lanes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lanes <= LCNT_W'(MAX_LANES))
        else $error("lane count beyond lane limit");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_valid || !i_stall))
        else $error("result overwrote a pending transfer");

    a_store_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        assign_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("assigned interval not stored");

    a_no_read_past_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |-> (r_idx < r_count))
        else $error("scan read beyond stored intervals");

endmodule

### rtl/interval_lane_allocator_core.sv
`timescale 1ns / 1ps

// Interval lane allocator.
// Input channel: i_valid with o_stall, carrying one interval (start, end,
// in-view flag, new-pass flag). A transfer happens on a clock edge with
// i_valid high and o_stall low. Output channel: o_valid with i_stall,
// carrying lane, lane total and status; one result per interval.
// min_lanes is written through i_cfg_we / i_cfg_data and takes effect at the
// next new pass; the user must write it only while the block is idle, and
// the block itself does not enforce this. Each interval is compared with
// every interval stored in the pass, one store read per cycle; at most 255
// are stored when an interval is scanned. Intervals out of view, or met by a
// full store, skip the scan. The next interval is taken once the previous
// one has been placed in the output register.
// A stalled result holds in the output register; the block can take and
// scan the next interval meanwhile, but waits before finishing it.
// Reset (synchronous, active low) empties the store, sets min_lanes to 3
// and the lane count to 3; no clearing pass is needed.
module interval_lane_allocator_core import ila_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [TIME_W-1:0] i_start_time,
    input  logic signed [TIME_W-1:0] i_end_time,
    input  logic                     i_in_view,
    input  logic                     i_new_pass,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [LANE_W-1:0]        o_lane,
    output logic [LCNT_W-1:0]        o_lane_total,
    output logic [STAT_W-1:0]        o_status
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    ila_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Store, scan and result datapath
    ila_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_start_time (i_start_time),
        .i_end_time   (i_end_time),
        .i_in_view    (i_in_view),
        .i_new_pass   (i_new_pass),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_lane       (o_lane),
        .o_lane_total (o_lane_total),
        .o_status     (o_status)
    );

endmodule
